// ===== sv/sync_length_frame_deframer_top_assert.svh =====
// Assertion macros for the sync-length frame deframer.
// Included by the top level; depends on nothing else.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/slfd_pkg.sv =====
// Shared types and constants for the sync-length frame deframer.
// Used by the interfaces and every module; depends on nothing.
`timescale 1ns / 1ps

package slfd_pkg;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hBC;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hB2;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_SECOND = 1'b1;

    localparam logic [11:0] SHORT_BODY_LIMIT = 12'd2;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_end;
        logic [15:0] message_id;
        logic [11:0] body_length;
        logic        short_body;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== sv/slfd_if.sv =====
// Handshake channel interfaces of the deframer: byte input, result output
// and register writes. Depends on slfd_pkg.
`timescale 1ns / 1ps

interface slfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slfd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [15:0] message_id;
    logic [11:0] body_length;
    logic        frame_end;
    logic        short_body;
    logic [31:0] frames_seen;

    modport source (
        output valid, output payload_byte, output has_byte, output message_id,
        output body_length, output frame_end, output short_body,
        output frames_seen, input ready
    );
    modport sink (
        input valid, input payload_byte, input has_byte, input message_id,
        input body_length, input frame_end, input short_body,
        input frames_seen, output ready
    );
endinterface

interface slfd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [slfd_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/slfd_front.sv =====
// Front end: holds the sync registers, tracks the frame phase for every
// accepted byte and queues payload and end commands. Depends on slfd_pkg.
`timescale 1ns / 1ps

module slfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    slfd_in_if.sink             i_in,
    slfd_cfg_if.sink            i_cfg,
    input  slfd_pkg::t_q_status i_q_stat,
    output logic                o_push,
    output slfd_pkg::t_cmd      o_cmd
);

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b0_0000_0001,
        PH_SYNC2   = 9'b0_0000_0010,
        PH_LEN_HI  = 9'b0_0000_0100,
        PH_LEN_LO  = 9'b0_0000_1000,
        PH_ID_HI   = 9'b0_0001_0000,
        PH_ID_LO   = 9'b0_0010_0000,
        PH_PAYLOAD = 9'b0_0100_0000,
        PH_CK1     = 9'b0_1000_0000,
        PH_CK2     = 9'b1_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [11:0] r_len, n_len;
    logic [11:0] r_left, n_left;
    logic [15:0] r_id, n_id;
    logic [7:0]  r_sync_first;
    logic [7:0]  r_sync_second;
    logic        w_acc;
    logic [7:0]  w_b;
    logic [11:0] w_left_dec;

    assign i_in.ready  = !i_q_stat.full;
    assign i_cfg.ready = 1'b1;
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_b         = i_in.rx_byte;
    assign w_left_dec  = r_left - 12'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= slfd_pkg::SYNC_FIRST_RST;
            r_sync_second <= slfd_pkg::SYNC_SECOND_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                slfd_pkg::CFG_IDX_SYNC_FIRST:  r_sync_first  <= i_cfg.data;
                slfd_pkg::CFG_IDX_SYNC_SECOND: r_sync_second <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_left  = r_left;
        n_id    = r_id;
        o_push  = 1'b0;
        o_cmd.payload_byte = w_b;
        o_cmd.is_end       = 1'b0;
        o_cmd.message_id   = r_id;
        o_cmd.body_length  = r_len;
        o_cmd.short_body   = 1'b0;
        if (w_acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_b == r_sync_first) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    priority if (w_b == r_sync_second) begin
                        n_phase = PH_LEN_HI;
                    end else if (w_b == r_sync_first) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN_HI: begin
                    n_len   = {w_b, 4'h0};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {r_len[11:4], w_b[7:4]};
                    n_left  = {r_len[11:4], w_b[7:4]};
                    n_id    = 16'h0000;
                    n_phase = (n_left == 12'd0) ? PH_CK1 : PH_ID_HI;
                end
                PH_ID_HI: begin
                    n_id    = {w_b, 8'h00};
                    n_left  = w_left_dec;
                    n_phase = (w_left_dec == 12'd0) ? PH_CK1 : PH_ID_LO;
                end
                PH_ID_LO: begin
                    n_id    = {r_id[15:8], w_b};
                    n_left  = w_left_dec;
                    n_phase = (w_left_dec == 12'd0) ? PH_CK1 : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_push  = 1'b1;
                    n_left  = w_left_dec;
                    n_phase = (w_left_dec == 12'd0) ? PH_CK1 : PH_PAYLOAD;
                end
                PH_CK1: begin
                    n_phase = PH_CK2;
                end
                PH_CK2: begin
                    o_push             = 1'b1;
                    o_cmd.payload_byte = 8'h00;
                    o_cmd.is_end       = 1'b1;
                    o_cmd.short_body   = (r_len < slfd_pkg::SHORT_BODY_LIMIT);
                    n_phase            = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 12'd0;
            r_left  <= 12'd0;
            r_id    <= 16'h0000;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_left  <= n_left;
            r_id    <= n_id;
        end
    end

endmodule

// ===== sv/slfd_queue.sv =====
// Short command queue between the front and back ends of the deframer.
// Depends on slfd_pkg; DEPTH must be a power of two of at least two.
`timescale 1ns / 1ps

module slfd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  slfd_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output slfd_pkg::t_cmd      o_cmd,
    output slfd_pkg::t_q_status o_stat
);

    localparam int unsigned AW = $clog2(DEPTH);

    slfd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [AW:0]    r_count, n_count;
    logic           w_wr;
    logic           w_rd;

    assign o_stat.full  = (r_count == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_wr         = i_push && !o_stat.full;
    assign w_rd         = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + (AW+1)'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== sv/slfd_back.sv =====
// Back end: takes queued commands into the output register, keeps the
// running frame count and drives the result channel. Depends on slfd_pkg.
`timescale 1ns / 1ps

module slfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slfd_pkg::t_cmd      i_cmd,
    input  slfd_pkg::t_q_status i_q_stat,
    output logic                o_pop,
    slfd_out_if.source          o_out
);

    logic           r_valid, n_valid;
    logic [31:0]    r_frames, n_frames;
    logic [31:0]    r_seen, n_seen;
    slfd_pkg::t_cmd r_cmd, n_cmd;
    logic           w_load;

    assign w_load = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign o_pop  = w_load;

    always_comb begin
        n_valid  = r_valid;
        n_frames = r_frames;
        n_seen   = r_seen;
        n_cmd    = r_cmd;
        if (w_load) begin
            n_valid = 1'b1;
            n_cmd   = i_cmd;
            if (i_cmd.is_end) begin
                n_frames = r_frames + 32'd1;
            end
            n_seen = n_frames;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_frames <= 32'd0;
        end else begin
            r_valid  <= n_valid;
            r_frames <= n_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_seen <= n_seen;
    end

    assign o_out.valid        = r_valid;
    assign o_out.payload_byte = r_cmd.payload_byte;
    assign o_out.has_byte     = !r_cmd.is_end;
    assign o_out.message_id   = r_cmd.message_id;
    assign o_out.body_length  = r_cmd.body_length;
    assign o_out.frame_end    = r_cmd.is_end;
    assign o_out.short_body   = r_cmd.short_body;
    assign o_out.frames_seen  = r_seen;

endmodule

// ===== sv/sync_length_frame_deframer_top.sv =====
// Sync-length frame deframer, top level.
// Throughput: one byte per cycle; the front end stalls only when the command queue is full.
// A byte's result is written into the queue, then loaded into the output register.
// Reset: synchronous, active low; returns to sync hunting, empties the queue, clears the
// frame count and restores the sync registers to 0xBC and 0xB2.
// Depends on slfd_pkg, slfd_if, slfd_front, slfd_queue, slfd_back and the assertion header.
`timescale 1ns / 1ps
`include "sync_length_frame_deframer_top_assert.svh"

module sync_length_frame_deframer_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slfd_in_if.sink    i_in,
    slfd_cfg_if.sink   i_cfg,
    slfd_out_if.source o_out
);

    logic                w_push;
    logic                w_pop;
    slfd_pkg::t_cmd      w_cmd_in;
    slfd_pkg::t_cmd      w_cmd_out;
    slfd_pkg::t_q_status w_q_stat;

    slfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    slfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_stat  (w_q_stat)
    );

    slfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd_out),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    `SLFD_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, !w_q_stat.empty, o_out.valid,
                      "queued command not presented")
    `SLFD_ASSERT_SAME(a_end_item_form, i_clk, i_rst_n, o_out.valid && o_out.frame_end,
                      !o_out.has_byte && (o_out.payload_byte == 8'h00),
                      "end item carries a byte")
    `SLFD_ASSERT_SAME(a_payload_form, i_clk, i_rst_n, o_out.valid && o_out.has_byte,
                      !o_out.frame_end && !o_out.short_body,
                      "payload item flagged as end")

endmodule
